### sv/trpb_pkg.sv
// trpb_pkg: shared constants, types and functions of the tempo ratio to pitch bend block
// no dependencies; compiled first

package trpb_pkg;

    localparam int LOG_FRACTION_BITS_DEF = 16;

    localparam int TEMPO_W     = 16;
    localparam int RANGE_W     = 11;
    localparam int BEND_W      = 14;
    localparam int CENTS_W     = 20;
    localparam int SEMIS_W     = 17;
    localparam int EXP_W       = 4;
    localparam int MANT_W      = 32;
    localparam int QUOT_W      = 14;

    localparam logic [RANGE_W-1:0] BEND_RANGE_RESET = 11'd64;
    localparam logic [BEND_W-1:0]  BEND_CENTRE      = 14'd8192;
    localparam logic [BEND_W-1:0]  BEND_MAX         = 14'd16383;
    localparam logic [BEND_W-1:0]  BEND_MIN         = 14'd0;
    localparam logic [BEND_W-1:0]  LIMIT_NEG        = 14'd8192;
    localparam logic [BEND_W-1:0]  LIMIT_POS        = 14'd8191;
    localparam logic [14:0]        CENTS_MUL        = 15'd19200;

    typedef struct packed {
        logic                bit_out;
        logic [MANT_W-1:0]   mant;
    } sq_step_t;

    // one truncating squaring step of the log2 fraction search
    function automatic sq_step_t sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] prod;
        logic [MANT_W:0]     sq;
        sq_step_t            r;
        prod = m * m;
        sq   = prod[2*MANT_W-1:MANT_W-1];
        r.bit_out = sq[MANT_W];
        r.mant    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        return r;
    endfunction

    // position of the leading one, zero for a zero word
    function automatic logic [EXP_W-1:0] lead_one(input logic [TEMPO_W-1:0] x);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < TEMPO_W; i++) begin
            if (x[i])
            begin
                e = EXP_W'(i);
            end
        end
        return e;
    endfunction

endpackage

### sv/trpb_if.sv
// trpb_if: valid/ready channel interfaces for tempo pairs, bend results and range writes
// depends on trpb_pkg

interface trpb_tempo_if;
    import trpb_pkg::*;
    logic               valid;
    logic               ready;
    logic [TEMPO_W-1:0] original_tempo;
    logic [TEMPO_W-1:0] target_tempo;
    modport source (output valid, output original_tempo, output target_tempo, input ready);
    modport sink   (input valid, input original_tempo, input target_tempo, output ready);
endinterface

interface trpb_bend_if;
    import trpb_pkg::*;
    logic                valid;
    logic                ready;
    logic [BEND_W-1:0]   bend_value;
    logic [CENTS_W-1:0]  shift_cents;
    logic [SEMIS_W-1:0]  shift_semitones;
    logic                out_of_range;
    logic                result_valid;
    modport source (output valid, output bend_value, output shift_cents,
                    output shift_semitones, output out_of_range, output result_valid,
                    input ready);
    modport sink   (input valid, input bend_value, input shift_cents,
                    input shift_semitones, input out_of_range, input result_valid,
                    output ready);
endinterface

interface trpb_cfg_if;
    import trpb_pkg::*;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/tempo_ratio_to_pitch_bend.sv
// tempo_ratio_to_pitch_bend: pipelined conversion of a tempo pair to a pitch bend
// throughput one tempo pair per cycle while the output is not stalled; the pipeline
// advances whenever the output register is empty or its transfer completes, so a
// stall holds every stage; the log2 squaring chain (one 32x32 square per stage)
// and the 14-stage restoring divider by the bend range set the depth
// rst_n clears all valid bits and sets bend_range to 64; payload is not reset

module tempo_ratio_to_pitch_bend
    import trpb_pkg::*;
#(
    parameter int LOG_FRACTION_BITS = LOG_FRACTION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    trpb_tempo_if.sink   tempo,
    trpb_bend_if.source  bend,
    trpb_cfg_if.sink     cfg
);

    localparam int F   = LOG_FRACTION_BITS;
    localparam int LW  = EXP_W + F;          // log2 word
    localparam int MW  = LW + 1;             // difference / magnitude
    localparam int CNW = MW + 15;            // cents product
    localparam int SNW = MW + 12;            // semitone product
    localparam int XW  = F + 27;             // dividend and compare width
    localparam int DW  = RANGE_W + F + 1;    // divisor width
    localparam int LMW = BEND_W + RANGE_W;   // limit product

    logic en;
    assign en = !bend.valid || bend.ready;
    assign tempo.ready = en;

    // bend range register
    logic [RANGE_W-1:0] range_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= BEND_RANGE_RESET;
        end
        else if (cfg.valid && (cfg.data != '0))
        begin
            range_reg <= cfg.data;
        end
    end

    // log2 squaring pipeline, stage 0 holds the normalized inputs
    logic              lv_reg [0:F];
    logic              lz_reg [0:F];
    logic [EXP_W-1:0]  ea_reg [0:F];
    logic [EXP_W-1:0]  eb_reg [0:F];
    logic [MANT_W-1:0] ma_reg [0:F];
    logic [MANT_W-1:0] mb_reg [0:F];
    logic [F-1:0]      fa_reg [0:F];
    logic [F-1:0]      fb_reg [0:F];

    logic [EXP_W-1:0] ea_next, eb_next;
    assign ea_next = lead_one(tempo.original_tempo);
    assign eb_next = lead_one(tempo.target_tempo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            lv_reg[0] <= tempo.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lz_reg[0] <= (tempo.original_tempo == '0) || (tempo.target_tempo == '0);
            ea_reg[0] <= ea_next;
            eb_reg[0] <= eb_next;
            ma_reg[0] <= MANT_W'(tempo.original_tempo) << (5'd31 - 5'(ea_next));
            mb_reg[0] <= MANT_W'(tempo.target_tempo) << (5'd31 - 5'(eb_next));
            fa_reg[0] <= '0;
            fb_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= F; k++)
    begin : g_log
        sq_step_t sa, sb;
        assign sa = sq_step(ma_reg[k-1]);
        assign sb = sq_step(mb_reg[k-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                lv_reg[k] <= lv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lz_reg[k] <= lz_reg[k-1];
                ea_reg[k] <= ea_reg[k-1];
                eb_reg[k] <= eb_reg[k-1];
                ma_reg[k] <= sa.mant;
                mb_reg[k] <= sb.mant;
                fa_reg[k] <= {fa_reg[k-1][F-2:0], sa.bit_out};
                fb_reg[k] <= {fb_reg[k-1][F-2:0], sb.bit_out};
            end
        end
    end

    // log difference as sign and magnitude
    logic          dv_reg, dz_reg, dn_reg;
    logic [MW-1:0] dm_reg;
    logic [MW-1:0] diff;
    assign diff = {1'b0, eb_reg[F], fb_reg[F]} - {1'b0, ea_reg[F], fa_reg[F]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg <= lv_reg[F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_reg <= lz_reg[F];
            dn_reg <= diff[MW-1];
            dm_reg <= diff[MW-1] ? (MW'(0) - diff) : diff;
        end
    end

    // scaling products
    logic           pv_reg, pz_reg, pn_reg;
    logic [CNW-1:0] pc_reg;
    logic [SNW-1:0] ps_reg;
    logic [XW-1:0]  px_reg;
    logic [XW-1:0]  pn19_reg;
    logic [LMW-1:0] pl_reg;
    logic [DW-1:0]  pd_reg;
    logic [MW+1:0]  mag3;
    assign mag3 = (MW+2)'(dm_reg) + ((MW+2)'(dm_reg) << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= dv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pz_reg   <= dz_reg;
            pn_reg   <= dn_reg;
            pc_reg   <= CNW'(dm_reg) * CNW'(CENTS_MUL);
            ps_reg   <= SNW'(mag3) << 10;
            px_reg   <= (XW'(mag3) << 20) + (XW'(range_reg) << F);
            pn19_reg <= XW'(mag3) << 19;
            pl_reg   <= LMW'(dn_reg ? LIMIT_NEG : LIMIT_POS) * LMW'(range_reg);
            pd_reg   <= DW'(range_reg) << (F + 1);
        end
    end

    // rounding, range check and divider load
    localparam logic [CNW:0] CHALF = (CNW+1)'(1) << (F - 1);
    localparam logic [SNW:0] SHALF = (SNW+1)'(1) << (F - 1);
    logic [CNW:0] csum;
    logic [SNW:0] ssum;
    assign csum = (CNW+1)'(pc_reg) + CHALF;
    assign ssum = (SNW+1)'(ps_reg) + SHALF;

    logic              qv_reg [0:QUOT_W];
    logic              qz_reg [0:QUOT_W];
    logic              qn_reg [0:QUOT_W];
    logic              qo_reg [0:QUOT_W];
    logic [CENTS_W-1:0] qc_reg [0:QUOT_W];
    logic [SEMIS_W-1:0] qs_reg [0:QUOT_W];
    logic [XW-1:0]     qr_reg [0:QUOT_W];
    logic [QUOT_W-1:0] qq_reg [0:QUOT_W];
    logic [DW-1:0]     qd_reg [0:QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            qv_reg[0] <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qz_reg[0] <= pz_reg;
            qn_reg[0] <= pn_reg;
            qo_reg[0] <= pn19_reg > (XW'(pl_reg) << F);
            qc_reg[0] <= CENTS_W'(csum >> F);
            qs_reg[0] <= SEMIS_W'(ssum >> F);
            qr_reg[0] <= px_reg;
            qq_reg[0] <= '0;
            qd_reg[0] <= pd_reg;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar j = 1; j <= QUOT_W; j++)
    begin : g_div
        logic [XW-1:0] trial;
        logic          take;
        assign trial = XW'(qd_reg[j-1]) << (QUOT_W - j);
        assign take  = qr_reg[j-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                qv_reg[j] <= qv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qz_reg[j] <= qz_reg[j-1];
                qn_reg[j] <= qn_reg[j-1];
                qo_reg[j] <= qo_reg[j-1];
                qc_reg[j] <= qc_reg[j-1];
                qs_reg[j] <= qs_reg[j-1];
                qd_reg[j] <= qd_reg[j-1];
                qr_reg[j] <= take ? (qr_reg[j-1] - trial) : qr_reg[j-1];
                qq_reg[j] <= qq_reg[j-1] | (take ? (QUOT_W'(1) << (QUOT_W - j)) : '0);
            end
        end
    end

    // output register
    logic                out_v_reg;
    logic [BEND_W-1:0]   bend_reg;
    logic [CENTS_W-1:0]  cents_reg;
    logic [SEMIS_W-1:0]  semis_reg;
    logic                oor_reg;
    logic                rv_reg;
    logic [BEND_W-1:0]   bend_next;
    logic                zq, nq;

    assign zq = qz_reg[QUOT_W];
    assign nq = qn_reg[QUOT_W];

    always_comb
    begin
        if (qo_reg[QUOT_W])
        begin
            bend_next = nq ? BEND_MIN : BEND_MAX;
        end
        else if (nq)
        begin
            bend_next = BEND_CENTRE - qq_reg[QUOT_W];
        end
        else
        begin
            bend_next = BEND_CENTRE + qq_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= qv_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bend_reg  <= zq ? BEND_CENTRE : bend_next;
            cents_reg <= zq ? '0 : (nq ? (CENTS_W'(0) - qc_reg[QUOT_W]) : qc_reg[QUOT_W]);
            semis_reg <= zq ? '0 : (nq ? (SEMIS_W'(0) - qs_reg[QUOT_W]) : qs_reg[QUOT_W]);
            oor_reg   <= !zq && qo_reg[QUOT_W];
            rv_reg    <= !zq;
        end
    end

    assign bend.valid           = out_v_reg;
    assign bend.bend_value      = bend_reg;
    assign bend.shift_cents     = cents_reg;
    assign bend.shift_semitones = semis_reg;
    assign bend.out_of_range    = oor_reg;
    assign bend.result_valid    = rv_reg;

endmodule

### test/tempo_ratio_to_pitch_bend_tb.sv
// tempo_ratio_to_pitch_bend_tb: self-checking bench for the tempo ratio to pitch bend block
// depends on trpb_pkg, trpb_if and tempo_ratio_to_pitch_bend

module tempo_ratio_to_pitch_bend_tb;
    import trpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = LOG_FRACTION_BITS_DEF;
    localparam int LATENCY      = FRAC_BITS + 19;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct packed {
        logic [TEMPO_W-1:0] original_tempo;
        logic [TEMPO_W-1:0] target_tempo;
    } tempo_pair_t;

    typedef struct packed {
        logic [BEND_W-1:0]  bend_value;
        logic [CENTS_W-1:0] shift_cents;
        logic [SEMIS_W-1:0] shift_semitones;
        logic               out_of_range;
        logic               result_valid;
    } bend_result_t;

    logic clk;
    logic rst_n;

    trpb_tempo_if tempo_ch();
    trpb_bend_if  bend_ch();
    trpb_cfg_if   cfg_ch();

    tempo_ratio_to_pitch_bend u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tempo (tempo_ch),
        .bend  (bend_ch),
        .cfg   (cfg_ch)
    );

    tempo_pair_t  pending_pairs[$];
    bend_result_t expected_bends[$];
    logic [RANGE_W-1:0] model_range;
    int  mismatch_count;
    int  result_count;
    int  sent_count;
    int  range_writes;
    bit  out_idle_free;
    bit  in_idle_free;
    int  hold_off_cycles;
    bit  hold_off_request;
    bit  hold_off_done;

    // fixed-point log2 of one tempo, integer part over FRAC_BITS fraction bits
    function automatic longint unsigned tempo_log2(input logic [TEMPO_W-1:0] x);
        longint unsigned m;
        longint unsigned frac;
        int e;
        e = 0;
        frac = 0;
        for (int i = 0; i < TEMPO_W; i++)
        begin
            if (x[i])
            begin
                e = i;
            end
        end
        m = longint'(x) << (31 - e);
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << FRAC_BITS) | frac;
    endfunction

    function automatic longint unsigned round_quot(input longint unsigned num,
                                                   input longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    // expected bend, shift and flags for one tempo pair
    function automatic bend_result_t predict_bend(input tempo_pair_t p,
                                                  input logic [RANGE_W-1:0] rng);
        bend_result_t r;
        longint d;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint cents;
        longint semis;
        longint offset;
        longint bend;
        bit oor;
        if (p.original_tempo == 0 || p.target_tempo == 0)
        begin
            r = '0;
            r.bend_value = BEND_CENTRE;
            return r;
        end
        d = longint'(tempo_log2(p.target_tempo)) - longint'(tempo_log2(p.original_tempo));
        mag = (d < 0) ? -d : d;
        cents = round_quot(mag * 19200, 64'd1 << FRAC_BITS);
        semis = round_quot(mag * 3072, 64'd1 << FRAC_BITS);
        num = mag * 1572864;
        den = longint'(rng) << FRAC_BITS;
        oor = (d < 0) ? (num > 8192 * den) : (num > 8191 * den);
        offset = round_quot(num, den);
        if (d < 0)
        begin
            cents = -cents;
            semis = -semis;
            offset = -offset;
        end
        bend = 8192 + offset;
        if (bend < 0)
        begin
            bend = 0;
        end
        else if (bend > 16383)
        begin
            bend = 16383;
        end
        r.bend_value      = bend[BEND_W-1:0];
        r.shift_cents     = cents[CENTS_W-1:0];
        r.shift_semitones = semis[SEMIS_W-1:0];
        r.out_of_range    = oor;
        r.result_valid    = 1'b1;
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // input driver: offers queued tempo pairs, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_ch.valid          <= 1'b0;
            tempo_ch.original_tempo <= '0;
            tempo_ch.target_tempo   <= '0;
        end
        else
        begin
            if (!tempo_ch.valid || tempo_ch.ready)
            begin
                if (tempo_ch.valid)
                begin
                    expected_bends.push_back(predict_bend({tempo_ch.original_tempo,
                                                           tempo_ch.target_tempo},
                                                          model_range));
                    sent_count++;
                end
                if (pending_pairs.size() > 0 && (in_idle_free || $urandom_range(99) >= 28))
                begin
                    tempo_ch.valid          <= 1'b1;
                    tempo_ch.original_tempo <= pending_pairs[0].original_tempo;
                    tempo_ch.target_tempo   <= pending_pairs[0].target_tempo;
                    void'(pending_pairs.pop_front());
                end
                else
                begin
                    tempo_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, counted down once on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_cycles <= 0;
            hold_off_done   <= 1'b0;
        end
        else if (hold_off_request && !hold_off_done)
        begin
            hold_off_cycles <= HOLD_OFF_LEN;
            hold_off_done   <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
        end
    end

    // output monitor: checks each result transfer, random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_ch.ready <= 1'b0;
        end
        else
        begin
            if (bend_ch.valid && bend_ch.ready)
            begin
                result_count++;
                if (expected_bends.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected result: bend %0d", bend_ch.bend_value);
                    end
                end
                else if (expected_bends[0] != {bend_ch.bend_value, bend_ch.shift_cents,
                                                bend_ch.shift_semitones,
                                                bend_ch.out_of_range, bend_ch.result_valid})
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected bend %0d cents %0d semis %0d oor %0b vld %0b",
                                 expected_bends[0].bend_value,
                                 $signed(expected_bends[0].shift_cents),
                                 $signed(expected_bends[0].shift_semitones),
                                 expected_bends[0].out_of_range,
                                 expected_bends[0].result_valid);
                        $display("          actual   bend %0d cents %0d semis %0d oor %0b vld %0b",
                                 bend_ch.bend_value, $signed(bend_ch.shift_cents),
                                 $signed(bend_ch.shift_semitones),
                                 bend_ch.out_of_range, bend_ch.result_valid);
                    end
                end
                if (expected_bends.size() > 0)
                begin
                    void'(expected_bends.pop_front());
                end
            end
            if (hold_off_cycles > 0)
            begin
                bend_ch.ready <= 1'b0;
            end
            else
            begin
                bend_ch.ready <= out_idle_free || ($urandom_range(99) >= 28);
            end
        end
    end

    // range write through the config channel, only while idle
    task automatic write_range(input logic [RANGE_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (value != 0)
        begin
            model_range = value;
        end
        range_writes++;
    endtask

    // wait until nothing is queued, offered or in flight
    task automatic drain_pipeline();
        while (pending_pairs.size() > 0 || tempo_ch.valid || expected_bends.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [TEMPO_W-1:0] random_tempo();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return TEMPO_W'($urandom_range(3));
        end
        else if (sel == 1)
        begin
            return TEMPO_W'(32'hFFFF - $urandom_range(3));
        end
        else if (sel <= 4)
        begin
            return TEMPO_W'($urandom_range(6000, 24000));
        end
        return TEMPO_W'($urandom_range(1, 65535));
    endfunction

    task automatic queue_random(input int count);
        tempo_pair_t p;
        for (int i = 0; i < count; i++)
        begin
            p.original_tempo = random_tempo();
            if ($urandom_range(3) == 0)
            begin
                p.target_tempo = random_tempo();
            end
            else
            begin
                // nearby tempo: small realistic bends
                p.target_tempo = TEMPO_W'(32'(p.original_tempo) + $urandom_range(2000) - 1000);
                if ($urandom_range(19) == 0)
                begin
                    p.target_tempo = '0;
                end
            end
            pending_pairs.push_back(p);
        end
    endtask

    // stimulus
    initial
    begin
        logic [RANGE_W-1:0] ranges[6];
        mismatch_count = 0;
        result_count = 0;
        sent_count = 0;
        range_writes = 0;
        hold_off_request = 1'b0;
        out_idle_free = 1'b0;
        in_idle_free = 1'b0;
        model_range = BEND_RANGE_RESET;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero tempos, equal tempos, one-lsb ratios
        pending_pairs.push_back({16'd0, 16'd12000});
        pending_pairs.push_back({16'd12000, 16'd0});
        pending_pairs.push_back({16'd0, 16'd0});
        pending_pairs.push_back({16'd12000, 16'd12000});
        pending_pairs.push_back({16'd1, 16'd65535});
        pending_pairs.push_back({16'd65535, 16'd1});
        pending_pairs.push_back({16'd1, 16'd1});
        pending_pairs.push_back({16'd65535, 16'd65535});
        pending_pairs.push_back({16'd12000, 16'd24000});
        pending_pairs.push_back({16'd24000, 16'd12000});
        pending_pairs.push_back({16'd12000, 16'd15119});
        pending_pairs.push_back({16'd12000, 16'd9524});
        pending_pairs.push_back({16'd32768, 16'd32767});
        pending_pairs.push_back({16'd21845, 16'd43690});
        pending_pairs.push_back({16'd12000, 16'd12001});
        pending_pairs.push_back({16'd12001, 16'd12000});
        drain_pipeline();

        // ranges: minimum, maximum, beyond limit, zero write ignored, 24, reset value
        ranges = '{11'd1, 11'd1536, 11'd2047, 11'd0, 11'd24, 11'd64};
        foreach (ranges[k])
        begin
            write_range(ranges[k]);
            pending_pairs.push_back({16'd12000, 16'd12001});
            pending_pairs.push_back({16'd12000, 16'd24000});
            pending_pairs.push_back({16'd24000, 16'd12000});
            pending_pairs.push_back({16'd1, 16'd65535});
            queue_random(260);
            // one phase without idling, one with a long output hold-off
            if (k == 1)
            begin
                in_idle_free = 1'b1;
                out_idle_free = 1'b1;
            end
            if (k == 2)
            begin
                hold_off_request = 1'b1;
            end
            drain_pipeline();
            in_idle_free = 1'b0;
            out_idle_free = 1'b0;
        end

        $display("sent %0d tempo pairs, checked %0d results over %0d range writes",
                 sent_count, result_count, range_writes);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/trpb_pkg.sv
sv/trpb_if.sv
sv/tempo_ratio_to_pitch_bend.sv
test/tempo_ratio_to_pitch_bend_tb.sv
